>>> sv/cnh_pkg.sv
// Shared types, constants and the letter coding function for the n-gram histogram.
package cnh_pkg;

  localparam int BYTE_COUNT_BITS_DEF  = 32;
  localparam int NGRAM_COUNT_BITS_DEF = 16;
  localparam int LETTER_BITS          = 6;
  localparam int HIST_DEPTH           = 256;
  localparam int HIST_AW              = 8;
  localparam int PAIR_DEPTH           = 4096;
  localparam int PAIR_AW              = 2 * LETTER_BITS;
  localparam int TRIPLE_DEPTH         = 262144;
  localparam int TRIPLE_AW            = 3 * LETTER_BITS;

  typedef enum logic [1:0] {
    REQ_FEED        = 2'd0,
    REQ_READ_BYTE   = 2'd1,
    REQ_READ_PAIR   = 2'd2,
    REQ_READ_TRIPLE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_UPD   = 2'd2
  } state_t;

  typedef struct packed {
    logic                   ok;
    logic [LETTER_BITS-1:0] code;
  } letter_t;

  // A-Z map to 0..25 and a-z to 26..51; any other byte is not a letter.
  function automatic letter_t letter_code(input logic [7:0] b);
    letter_t l;
    l.ok   = 1'b0;
    l.code = '0;
    if (b >= 8'h41 && b <= 8'h5a) begin
      l.ok   = 1'b1;
      l.code = LETTER_BITS'(b - 8'h41);
    end else if (b >= 8'h61 && b <= 8'h7a) begin
      l.ok   = 1'b1;
      l.code = LETTER_BITS'(b - 8'h61 + 8'd26);
    end
    return l;
  endfunction

endpackage

>>> sv/char_ngram_histogram_top.sv
// Byte, letter pair and letter triple histogram with feed and read requests.
// The request and RAM reads are registered at the transfer, the result in the update
// state once the output is free; no new request is taken until then (RAM read, then
// modify and write back). Reset: rst_n runs a clearing pass over all three tables;
// no input is taken during it. The byte history resets to zero.
module char_ngram_histogram_top
  import cnh_pkg::*;
#(
  parameter int BYTE_COUNT_BITS  = BYTE_COUNT_BITS_DEF,
  parameter int NGRAM_COUNT_BITS = NGRAM_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [7:0]                  in_data_byte,
  input  logic [7:0]                  in_byte_b,
  input  logic [7:0]                  in_byte_c,
  input  logic                        in_new_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [BYTE_COUNT_BITS-1:0]  out_byte_count,
  output logic [NGRAM_COUNT_BITS-1:0] out_pair_count,
  output logic [NGRAM_COUNT_BITS-1:0] out_triple_count,
  output logic                        out_pair_counted,
  output logic                        out_triple_counted
);

  state_t state_r, state_nxt;
  logic [TRIPLE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [7:0] prev_r, prev_nxt, prev_prev_r, prev_prev_nxt;

  // Request held for the update cycle.
  req_t                 req_r;
  logic [7:0]           byte_r;
  logic                 new_text_r;
  logic                 pair_ok_r, trip_ok_r;
  logic [PAIR_AW-1:0]   pair_addr_r;
  logic [TRIPLE_AW-1:0] trip_addr_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [BYTE_COUNT_BITS-1:0]  out_byte_count_r;
  logic [NGRAM_COUNT_BITS-1:0] out_pair_count_r, out_triple_count_r;
  logic                        out_pair_counted_r, out_triple_counted_r;

  logic in_xfer, upd_go, clearing;
  logic [7:0] eff_prev, eff_prev_prev;
  letter_t    l_a, l_b, l_c, l_p, l_pp;
  logic                 pair_ok, trip_ok;
  logic [PAIR_AW-1:0]   pair_addr;
  logic [TRIPLE_AW-1:0] trip_addr;

  logic                        hist_we, pair_we, trip_we;
  logic [HIST_AW-1:0]          hist_waddr;
  logic [PAIR_AW-1:0]          pair_waddr;
  logic [TRIPLE_AW-1:0]        trip_waddr;
  logic [BYTE_COUNT_BITS-1:0]  hist_q, hist_new, hist_wdata;
  logic [NGRAM_COUNT_BITS-1:0] pair_q, pair_new, pair_wdata;
  logic [NGRAM_COUNT_BITS-1:0] trip_q, trip_new, trip_wdata;
  logic                        is_feed;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_UPD;
      ST_UPD:   if (upd_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    clearing = 1'b0;
    upd_go   = 1'b0;
    unique case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_UPD:   upd_go   = !out_valid_r || out_ready;
      default:  clearing = 1'b0;
    endcase
  end

  assign in_xfer     = in_valid && in_ready;
  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : '0;

  // Address decode at transfer time; the history registers do not move until write back.
  always_comb begin
    eff_prev      = in_new_text ? 8'd0 : prev_r;
    eff_prev_prev = in_new_text ? 8'd0 : prev_prev_r;
    l_a  = letter_code(in_data_byte);
    l_b  = letter_code(in_byte_b);
    l_c  = letter_code(in_byte_c);
    l_p  = letter_code(eff_prev);
    l_pp = letter_code(eff_prev_prev);
    if (req_t'(in_req_type) == REQ_FEED) begin
      pair_ok   = l_p.ok && l_a.ok;
      trip_ok   = l_pp.ok && l_p.ok && l_a.ok;
      pair_addr = {l_p.code, l_a.code};
      trip_addr = {l_pp.code, l_p.code, l_a.code};
    end else begin
      pair_ok   = l_a.ok && l_b.ok;
      trip_ok   = l_a.ok && l_b.ok && l_c.ok;
      pair_addr = {l_a.code, l_b.code};
      trip_addr = {l_a.code, l_b.code, l_c.code};
    end
  end

  // Modify and write back; during the clearing pass, write zeros instead.
  always_comb begin
    is_feed    = (req_r == REQ_FEED);
    hist_new   = (hist_q == '1) ? hist_q : hist_q + 1'b1;
    pair_new   = pair_q + 1'b1;
    trip_new   = trip_q + 1'b1;
    hist_we    = clearing || (upd_go && is_feed);
    pair_we    = clearing || (upd_go && is_feed && pair_ok_r);
    trip_we    = clearing || (upd_go && is_feed && trip_ok_r);
    hist_waddr = clearing ? clr_cnt_r[HIST_AW-1:0] : byte_r;
    pair_waddr = clearing ? clr_cnt_r[PAIR_AW-1:0] : pair_addr_r;
    trip_waddr = clearing ? clr_cnt_r : trip_addr_r;
    hist_wdata = clearing ? '0 : hist_new;
    pair_wdata = clearing ? '0 : pair_new;
    trip_wdata = clearing ? '0 : trip_new;
  end

  always_comb begin
    prev_nxt      = prev_r;
    prev_prev_nxt = prev_prev_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_go) begin
      out_valid_nxt = 1'b1;
      if (is_feed) begin
        prev_prev_nxt = new_text_r ? 8'd0 : prev_r;
        prev_nxt      = byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      prev_r      <= '0;
      prev_prev_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      prev_r      <= prev_nxt;
      prev_prev_r <= prev_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r       <= req_t'(in_req_type);
      byte_r      <= in_data_byte;
      new_text_r  <= in_new_text;
      pair_ok_r   <= pair_ok;
      trip_ok_r   <= trip_ok;
      pair_addr_r <= pair_addr;
      trip_addr_r <= trip_addr;
    end
    if (upd_go) begin
      out_pair_counted_r   <= is_feed && pair_ok_r;
      out_triple_counted_r <= is_feed && trip_ok_r;
      case (req_r)
        REQ_FEED: begin
          out_byte_count_r   <= hist_new;
          out_pair_count_r   <= pair_ok_r ? pair_new : '0;
          out_triple_count_r <= trip_ok_r ? trip_new : '0;
        end
        REQ_READ_BYTE: begin
          out_byte_count_r   <= hist_q;
          out_pair_count_r   <= '0;
          out_triple_count_r <= '0;
        end
        REQ_READ_PAIR: begin
          out_byte_count_r   <= '0;
          out_pair_count_r   <= pair_ok_r ? pair_q : '0;
          out_triple_count_r <= '0;
        end
        default: begin
          out_byte_count_r   <= '0;
          out_pair_count_r   <= '0;
          out_triple_count_r <= trip_ok_r ? trip_q : '0;
        end
      endcase
    end
  end

  cnh_ram #(.WIDTH(BYTE_COUNT_BITS), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (in_xfer),
    .raddr (in_data_byte),
    .rdata (hist_q)
  );

  cnh_ram #(.WIDTH(NGRAM_COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (in_xfer),
    .raddr (pair_addr),
    .rdata (pair_q)
  );

  cnh_ram #(.WIDTH(NGRAM_COUNT_BITS), .DEPTH(TRIPLE_DEPTH)) u_trip_ram (
    .clk   (clk),
    .we    (trip_we),
    .waddr (trip_waddr),
    .wdata (trip_wdata),
    .re    (in_xfer),
    .raddr (trip_addr),
    .rdata (trip_q)
  );

  assign out_valid          = out_valid_r;
  assign out_byte_count     = out_byte_count_r;
  assign out_pair_count     = out_pair_count_r;
  assign out_triple_count   = out_triple_count_r;
  assign out_pair_counted   = out_pair_counted_r;
  assign out_triple_counted = out_triple_counted_r;

  a_rose_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_UPD)
    else $error("result appeared without an update cycle");

  a_triple_implies_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_triple_counted_r) |-> out_pair_counted_r)
    else $error("triple counted without its pair");

  a_feed_byte_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pair_counted_r) |-> out_byte_count_r != '0)
    else $error("fed byte reports a zero count");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(hist_we || pair_we || trip_we))
    else $error("table written while idle");

endmodule

>>> sv/cnh_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cnh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
